@@ hdl/md5_stream_hash_defines.svh @@
// assertion macros used by the checker of the md5 stream hash
`ifndef MD5_STREAM_HASH_DEFINES_SVH
`define MD5_STREAM_HASH_DEFINES_SVH

// same-cycle implication
`define MD5SH_ASSERT_IMP(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define MD5SH_ASSERT_NXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ hdl/md5sh_pkg.sv @@
package md5sh_pkg;

    typedef logic [31:0] t_word;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_READ,
        S_ROUND,
        S_FOLD,
        S_OUT
    } t_state;

    localparam logic ACT_ABSORB = 1'b0;
    localparam logic ACT_FINISH = 1'b1;

    localparam int unsigned BUF_WORDS = 16;
    localparam int unsigned BUF_AW    = $clog2(BUF_WORDS);

    localparam t_word CHAIN_INIT [4] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
    };

    localparam t_word ROUND_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] ROT_TBL [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    // message word used by round i
    function automatic logic [3:0] md5_g(input logic [5:0] i);
        logic [3:0] ii;
        logic [3:0] g;
        ii = i[3:0];
        case (i[5:4])
            2'd0:    g = ii;
            2'd1:    g = 4'(ii * 4'd5 + 4'd1);
            2'd2:    g = 4'(ii * 4'd3 + 4'd5);
            default: g = 4'(ii * 4'd7);
        endcase
        return g;
    endfunction

    function automatic t_word md5_f(input logic [1:0] phase, input t_word b,
                                    input t_word c, input t_word d);
        t_word f;
        case (phase)
            2'd0:    f = (b & c) | (~b & d);
            2'd1:    f = (b & d) | (c & ~d);
            2'd2:    f = b ^ c ^ d;
            default: f = c ^ (b | ~d);
        endcase
        return f;
    endfunction

    function automatic t_word md5_rotl(input t_word v, input logic [4:0] s);
        logic [63:0] t;
        t = {v, v} << s;
        return t[63:32];
    endfunction

endpackage

@@ hdl/md5_stream_hash.sv @@
// absorb: a beat is taken while idle; the beat that fills a 64-byte block then stalls
//   the input through one read set-up, 64 rounds and one fold
// finish: the 0x80 marker, any zero bytes and the bit length are padded in, compressing one
//   or two blocks, then four digest beats, one per cycle while the output is not stalled
// throughput: one byte per cycle while idle, between blocks; one md5 round per cycle in the core
// reset: synchronous, active low; chaining words to the md5 initial values, counts
//   cleared; the block buffer ram has no reset and every word is written before use
module md5_stream_hash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_action,
    input  logic [7:0]  i_data_byte,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_digest_word,
    output logic [1:0]  o_word_index,
    output logic        o_last_word
);

    import md5sh_pkg::*;

    // control state
    t_state      r_state, n_state;
    logic [5:0]  r_fill, n_fill;        // byte position within the current block
    logic [60:0] r_bytes, n_bytes;      // message length in bytes, bit count is this times 8
    logic        r_pad_act, n_pad_act;  // finish in progress
    logic        r_pad_first, n_pad_first;
    logic        r_len_phase, n_len_phase;
    logic [5:0]  r_round, n_round;
    logic [1:0]  r_oidx, n_oidx;
    t_word       r_chain [4];
    t_word       n_chain [4];

    // payload registers
    t_word       r_word, n_word;        // word being assembled, lanes low byte first
    t_word       r_a, r_b, r_c, r_d;
    t_word       n_a, n_b, n_c, n_d;

    // buffer ram port
    logic              ram_we;
    logic [BUF_AW-1:0] ram_waddr;
    t_word             ram_wdata;
    logic [BUF_AW-1:0] ram_raddr;
    t_word             ram_rdata;

    // byte push path, shared by absorb and padding
    logic        push;
    logic [7:0]  push_byte;
    logic        len_now;
    logic [63:0] len_bits;
    t_word       rnd_sum;

    md5sh_ram #(
        .WIDTH (32),
        .DEPTH (BUF_WORDS)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign len_bits = {r_bytes, 3'b000};
    // the length goes in from byte 56, after the 0x80 marker and any zero run
    assign len_now  = r_len_phase || (r_fill == 6'd56);
    assign rnd_sum  = r_a + md5_f(r_round[5:4], r_b, r_c, r_d) + ROUND_K[r_round] + ram_rdata;

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_bytes     = r_bytes;
        n_pad_act   = r_pad_act;
        n_pad_first = r_pad_first;
        n_len_phase = r_len_phase;
        n_round     = r_round;
        n_oidx      = r_oidx;
        n_chain     = r_chain;
        n_word      = r_word;
        n_a         = r_a;
        n_b         = r_b;
        n_c         = r_c;
        n_d         = r_d;
        push        = 1'b0;
        push_byte   = 8'h00;
        ram_raddr   = md5_g(6'(r_round + 6'd1));

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_action == ACT_FINISH) begin
                        n_state     = S_PAD;
                        n_pad_act   = 1'b1;
                        n_pad_first = 1'b1;
                        n_len_phase = 1'b0;
                    end else begin
                        push      = 1'b1;
                        push_byte = i_data_byte;
                        n_bytes   = r_bytes + 61'd1;
                    end
                end
            end
            S_PAD: begin
                push = 1'b1;
                if (r_pad_first) begin
                    push_byte   = 8'h80;
                    n_pad_first = 1'b0;
                end else if (len_now) begin
                    push_byte   = len_bits[{r_fill[2:0], 3'b000} +: 8];
                    n_len_phase = 1'b1;
                end else begin
                    push_byte = 8'h00;
                end
            end
            S_READ: begin
                // first message word fetched in the cycle before round 0
                ram_raddr = md5_g(6'd0);
                n_round   = 6'd0;
                n_a       = r_chain[0];
                n_b       = r_chain[1];
                n_c       = r_chain[2];
                n_d       = r_chain[3];
                n_state   = S_ROUND;
            end
            S_ROUND: begin
                n_a     = r_d;
                n_b     = r_b + md5_rotl(rnd_sum, ROT_TBL[{r_round[5:4], r_round[1:0]}]);
                n_c     = r_b;
                n_d     = r_c;
                n_round = 6'(r_round + 6'd1);
                if (r_round == 6'd63) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                n_chain[0] = r_chain[0] + r_a;
                n_chain[1] = r_chain[1] + r_b;
                n_chain[2] = r_chain[2] + r_c;
                n_chain[3] = r_chain[3] + r_d;
                n_oidx     = 2'd0;
                if (r_pad_act && r_len_phase) begin
                    n_state = S_OUT;
                end else if (r_pad_act) begin
                    n_state = S_PAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_oidx = 2'(r_oidx + 2'd1);
                    if (r_oidx == 2'd3) begin
                        // digest gone, back to the initial state for the next message
                        n_chain     = CHAIN_INIT;
                        n_bytes     = '0;
                        n_pad_act   = 1'b0;
                        n_len_phase = 1'b0;
                        n_state     = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        // byte into its lane, whole word to the ram on the fourth lane
        ram_we    = 1'b0;
        ram_waddr = r_fill[5:2];
        ram_wdata = {push_byte, r_word[23:0]};
        if (push) begin
            n_word[{r_fill[1:0], 3'b000} +: 8] = push_byte;
            n_fill = 6'(r_fill + 6'd1);
            if (r_fill[1:0] == 2'd3) begin
                ram_we = 1'b1;
            end
            if (r_fill == 6'd63) begin
                n_state = S_READ;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_bytes     <= '0;
            r_pad_act   <= 1'b0;
            r_pad_first <= 1'b0;
            r_len_phase <= 1'b0;
            r_round     <= '0;
            r_oidx      <= '0;
            r_chain     <= CHAIN_INIT;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_bytes     <= n_bytes;
            r_pad_act   <= n_pad_act;
            r_pad_first <= n_pad_first;
            r_len_phase <= n_len_phase;
            r_round     <= n_round;
            r_oidx      <= n_oidx;
            r_chain     <= n_chain;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_a    <= n_a;
        r_b    <= n_b;
        r_c    <= n_c;
        r_d    <= n_d;
    end

    // input is taken only while idle; the digest beats come straight from the chain
    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = (r_state == S_OUT);
    assign o_digest_word = r_chain[r_oidx];
    assign o_word_index  = r_oidx;
    assign o_last_word   = (r_oidx == 2'd3);

endmodule

@@ hdl/md5sh_ram.sv @@
module md5sh_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/md5sh_check.sv @@
`include "md5_stream_hash_defines.svh"

module md5sh_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_digest_word,
    input logic [1:0]  o_word_index,
    input logic        o_last_word
);

    `MD5SH_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_digest_word) && $stable(o_word_index), "stalled digest beat changed")
    `MD5SH_ASSERT_IMP(a_in_blocked, i_clk, i_rst_n, o_out_valid, o_in_stall, "input open during digest")
    `MD5SH_ASSERT_NXT(a_word_order, i_clk, i_rst_n, o_out_valid && !i_out_stall && !o_last_word, o_out_valid && (o_word_index == 2'($past(o_word_index) + 2'd1)), "digest words out of order")
    `MD5SH_ASSERT_IMP(a_last_flag, i_clk, i_rst_n, o_out_valid, o_last_word == (o_word_index == 2'd3), "last flag off final word")

endmodule

bind md5_stream_hash md5sh_check u_md5sh_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_digest_word (o_digest_word),
    .o_word_index  (o_word_index),
    .o_last_word   (o_last_word)
);

@@ bench/tb.sv @@
module tb;
    import md5sh_pkg::*;

    // generous bound: many times the work of the whole run
    localparam int CYCLE_LIMIT = 400000;
    // quiet cycles after the last digest beat before the verdict
    localparam int DRAIN_CYCLES = 80;

    // md5 initial chaining words
    localparam logic [31:0] IV_WORDS [4] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
    };

    // additive constants, one per round
    localparam logic [31:0] MIX_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // left-rotate amounts, four per phase
    localparam int ROT_AMT [16] = '{
        7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
    };

    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  idx;
        logic        last;
    } t_digest_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_action = ACT_ABSORB;
    logic [7:0]  in_byte = 8'h00;
    logic        out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [31:0] o_digest_word;
    logic [1:0]  o_word_index;
    logic        o_last_word;

    // shadow of the hash state, advanced on every accepted input beat
    logic [31:0] md_chain [4];
    logic [7:0]  md_block [64];
    logic [63:0] md_bits;
    logic [5:0]  md_fill;

    // digest words still owed by the block, oldest first
    t_digest_beat digest_q [$];

    int fail_count = 0;
    int beats_sent = 0;
    int cycle_count = 0;
    int stall_left = 0;
    // set for the closing stretch: no gaps and no back-pressure
    bit quiet = 1'b0;

    md5_stream_hash uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (o_in_stall),
        .i_action      (in_action),
        .i_data_byte   (in_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (out_stall),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

    always #4 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // digest predictor
    // ---------------------------------------------------------------

    function automatic void restart_digest();
        for (int k = 0; k < 4; k++) md_chain[k] = IV_WORDS[k];
        md_bits = 64'd0;
        md_fill = 6'd0;
    endfunction

    // 64 rounds over the full 64-byte block, folded into the chaining words
    function automatic void compress_block();
        logic [31:0] m [16];
        logic [31:0] a, b, c, d, f, t, sum;
        int g;
        int s;
        for (int k = 0; k < 16; k++)
            m[k] = {md_block[4*k+3], md_block[4*k+2], md_block[4*k+1], md_block[4*k]};
        a = md_chain[0];
        b = md_chain[1];
        c = md_chain[2];
        d = md_chain[3];
        for (int r = 0; r < 64; r++) begin
            case (r / 16)
                0: begin
                    f = (b & c) | (~b & d);
                    g = r;
                end
                1: begin
                    f = (b & d) | (c & ~d);
                    g = (5 * r + 1) % 16;
                end
                2: begin
                    f = b ^ c ^ d;
                    g = (3 * r + 5) % 16;
                end
                default: begin
                    f = c ^ (b | ~d);
                    g = (7 * r) % 16;
                end
            endcase
            s   = ROT_AMT[(r / 16) * 4 + r % 4];
            sum = a + f + MIX_K[r] + m[g];
            t   = d;
            d   = c;
            c   = b;
            b   = b + ((sum << s) | (sum >> (32 - s)));
            a   = t;
        end
        md_chain[0] = md_chain[0] + a;
        md_chain[1] = md_chain[1] + b;
        md_chain[2] = md_chain[2] + c;
        md_chain[3] = md_chain[3] + d;
    endfunction

    function automatic void push_block_byte(input logic [7:0] v);
        md_block[md_fill] = v;
        md_fill = md_fill + 6'd1;
        if (md_fill == 6'd0) compress_block();
    endfunction

    // advance the shadow state by one accepted beat; a finish queues four words
    function automatic void predict_beat(input logic act, input logic [7:0] v);
        logic [63:0] len;
        t_digest_beat e;
        if (act == ACT_ABSORB) begin
            md_bits = md_bits + 64'd8;
            push_block_byte(v);
        end else begin
            len = md_bits;
            push_block_byte(8'h80);
            while (md_fill != 6'd56) push_block_byte(8'h00);
            for (int k = 0; k < 8; k++) push_block_byte(len[8*k +: 8]);
            for (int k = 0; k < 4; k++) begin
                e.word = md_chain[k];
                e.idx  = 2'(k);
                e.last = (k == 3);
                digest_q = {digest_q, e};
            end
            restart_digest();
        end
    endfunction

    // ---------------------------------------------------------------
    // input side
    // ---------------------------------------------------------------

    // one input beat, with an occasional idle burst ahead of it
    task automatic send_beat(input logic act, input logic [7:0] v);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        in_valid  <= 1'b1;
        in_action <= act;
        in_byte   <= v;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_beat(act, v);
        beats_sent++;
    endtask

    // random bytes, then a finish carrying a random (ignored) byte
    task automatic send_message(input int len);
        for (int k = 0; k < len; k++) send_beat(ACT_ABSORB, 8'($urandom_range(0, 255)));
        send_beat(ACT_FINISH, 8'($urandom_range(0, 255)));
    endtask

    // mostly short messages, some spanning up to three blocks
    function automatic int pick_length();
        if ($urandom_range(0, 9) < 7) return $urandom_range(0, 20);
        return $urandom_range(21, 130);
    endfunction

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // finish with nothing absorbed: digest of the empty string
    task automatic test_empty_message();
        send_beat(ACT_FINISH, 8'hff);
    endtask

    // "abc", single extreme bytes, and a finish straight after a finish
    task automatic test_short_messages();
        send_beat(ACT_ABSORB, 8'h61);
        send_beat(ACT_ABSORB, 8'h62);
        send_beat(ACT_ABSORB, 8'h63);
        send_beat(ACT_FINISH, 8'h00);
        send_beat(ACT_ABSORB, 8'h00);
        send_beat(ACT_FINISH, 8'h5a);
        send_beat(ACT_ABSORB, 8'hff);
        send_beat(ACT_FINISH, 8'ha5);
        send_beat(ACT_FINISH, 8'h00);
    endtask

    // lengths where the padding just fits, spills into a second block,
    // or starts on a fresh block
    task automatic test_pad_boundaries();
        send_message(55);
        send_message(56);
        send_message(64);
    endtask

    // random lengths and content with input gaps and output back-pressure
    task automatic test_random_messages();
        int n;
        while (beats_sent < 280) begin
            n = pick_length();
            // cap the last message's bytes at the beats left in the budget
            if (n > 280 - beats_sent) n = 280 - beats_sent;
            send_message(n);
        end
    endtask

    // closing stretch at full rate
    task automatic test_unbroken_tail();
        quiet = 1'b1;
        while (beats_sent < 350) send_message($urandom_range(0, 20));
    endtask

    // ---------------------------------------------------------------
    // output side
    // ---------------------------------------------------------------

    // back-pressure in bursts of random length, released between bursts
    always @(posedge i_clk) begin
        if (!i_rst_n || quiet) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if (out_stall) begin
            out_stall <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 18);
        end
    end

    // every accepted digest beat against the oldest word owed
    always @(posedge i_clk) begin : check_digest
        t_digest_beat e;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (digest_q.size() == 0) begin
                $error("digest beat with none owed: word %h index %0d", o_digest_word,
                       o_word_index);
                fail_count++;
            end else begin
                e = digest_q.pop_front();
                if (o_digest_word !== e.word) begin
                    $error("digest_word: expected %h, got %h", e.word, o_digest_word);
                    fail_count++;
                end
                if (o_word_index !== e.idx) begin
                    $error("word_index: expected %0d, got %0d", e.idx, o_word_index);
                    fail_count++;
                end
                if (o_last_word !== e.last) begin
                    $error("last_word: expected %0d, got %0d", e.last, o_last_word);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("md5_stream_hash: mismatch");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------

    initial begin
        restart_digest();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_message();
        test_short_messages();
        test_pad_boundaries();
        test_random_messages();
        test_unbroken_tail();

        in_valid <= 1'b0;
        while (digest_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("md5_stream_hash: match");
        end else begin
            $display("md5_stream_hash: mismatch");
        end
        $finish;
    end

endmodule
